// File: rtl/core/sppf_pkg.sv
package sppf_pkg;

  localparam int MAX_PAGES_DEF      = 32;
  localparam int SLOTS_PER_PAGE_DEF = 16;
  localparam logic [15:0] PG_BYTES_RST = 16'd4096;
  localparam logic [19:0] HDR_BYTES  = 20'd16;
  localparam logic [19:0] SLOT_BYTES = 20'd4;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REPORT    = 3'd4;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        rec_bytes;
    logic signed [31:0] key;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  page_index;
    logic [3:0]  slot_index;
    logic [15:0] page_records;
    logic [5:0]  total_pages;
    logic        last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_PG_RD, S_PG_CHK, S_SCAN, S_NEWPG, S_UPD, S_EMIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic pg_inc;
    logic cap;
    logic scan_start;
    logic scan_step;
    logic open_new;
    logic upd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       pg_end;
    logic       fits;
    logic       scan_done;
    logic       found;
    logic       store_full;
    logic       rpt_empty;
    logic       rpt_last;
    logic       emit_ok;
  } sts_t;

endpackage

// File: rtl/core/sppf_ram.sv
module sppf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [AW-1:0]            raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/sppf_ctrl.sv
module sppf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  sppf_pkg::sts_t sts,
  output sppf_pkg::cmd_t cmd
);
  import sppf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_DISP;
      S_DISP: begin
        case (sts.op) inside
          OP_INSERT, OP_SEARCH: state_next = S_PG_RD;
          OP_REPORT: state_next = sts.rpt_empty ? S_EMIT : S_PG_RD;
          default:   state_next = S_IDLE;
        endcase
      end
      S_PG_RD: begin
        if (sts.pg_end) begin
          state_next = (sts.op == OP_INSERT) ? S_NEWPG : S_EMIT;
        end else begin
          state_next = S_PG_CHK;
        end
      end
      S_PG_CHK: begin
        if (sts.op == OP_INSERT) begin
          state_next = sts.fits ? S_SCAN : S_PG_RD;
        end else if (sts.op == OP_SEARCH) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          if (sts.op == OP_INSERT) begin
            state_next = S_UPD;
          end else begin
            state_next = sts.found ? S_EMIT : S_PG_RD;
          end
        end
      end
      S_NEWPG:  state_next = sts.store_full ? S_EMIT : S_UPD;
      S_UPD:    state_next = S_EMIT;
      S_EMIT: begin
        if (sts.emit_ok) begin
          state_next = (sts.op == OP_REPORT && !sts.rpt_last) ? S_PG_RD : S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE:   cmd.latch = in_valid;
      S_PG_CHK: begin
        cmd.cap = 1'b1;
        if (sts.op == OP_INSERT && !sts.fits) begin
          cmd.pg_inc = 1'b1;
        end
        if ((sts.op == OP_INSERT && sts.fits) || sts.op == OP_SEARCH) begin
          cmd.scan_start = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done && sts.op == OP_SEARCH && !sts.found) begin
          cmd.pg_inc = 1'b1;
        end
      end
      S_NEWPG:  cmd.open_new = !sts.store_full;
      S_UPD:    cmd.upd = 1'b1;
      S_EMIT: begin
        cmd.emit = sts.emit_ok;
        cmd.pg_inc = sts.emit_ok && sts.op == OP_REPORT && !sts.rpt_last;
      end
      default: ;
    endcase
  end
endmodule

// File: rtl/core/sppf_dpath.sv
module sppf_dpath #(
  parameter int MAX_PAGES      = sppf_pkg::MAX_PAGES_DEF,
  parameter int SLOTS_PER_PAGE = sppf_pkg::SLOTS_PER_PAGE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  sppf_pkg::in_t  in_data,
  input  logic           cfg_valid,
  input  logic [15:0]    cfg_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sppf_pkg::out_t out_data,
  input  sppf_pkg::cmd_t cmd,
  output sppf_pkg::sts_t sts
);
  import sppf_pkg::*;

  localparam int PW    = $clog2(MAX_PAGES + 1);
  localparam int PGW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int SW1   = $clog2(SLOTS_PER_PAGE + 1);
  localparam int SW    = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
  localparam int PWORD = SW1 + 32;

  logic [15:0]    pg_bytes;
  in_t            req;
  logic [PW-1:0]  pg, open;
  logic [15:0]    fo, rc;
  logic [SW1-1:0] fill, sc, rank;
  logic           kv, found;

  logic [PWORD-1:0] pq, pwdata;
  logic [31:0]      kq;
  logic [SW1-1:0]   pq_fill, fill_n;
  logic [15:0]      pq_rc, pq_fo, rc_n, fo_n;
  logic [16:0]      fo_sum;
  logic [19:0]      need;
  logic             eq, lt;
  out_t             out_next;

  assign pq_fill = pq[PWORD-1:32];
  assign pq_rc   = pq[31:16];
  assign pq_fo   = pq[15:0];
  assign need    = 20'(pq_fo) + HDR_BYTES + {2'b00, pq_rc, 2'b00}
                 + 20'(req.rec_bytes) + SLOT_BYTES;

  assign fo_sum = 17'(fo) + 17'(req.rec_bytes);
  assign fo_n   = fo_sum[16] ? 16'hFFFF : fo_sum[15:0];
  assign rc_n   = (rc == 16'hFFFF) ? rc : rc + 16'd1;
  assign fill_n = found ? fill : fill + SW1'(1);
  assign pwdata = {fill_n, rc_n, fo_n};

  sppf_ram #(.WIDTH(PWORD), .DEPTH(1 << PGW)) u_page_ram (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (pg[PGW-1:0]),
    .wdata (pwdata),
    .raddr (pg[PGW-1:0]),
    .rdata (pq)
  );

  // slot directory: row per page, new keys go to the first unused slot
  sppf_ram #(.WIDTH(32), .DEPTH(1 << (PGW + SW))) u_key_ram (
    .clk   (clk),
    .we    (cmd.upd && !found),
    .waddr ({pg[PGW-1:0], fill[SW-1:0]}),
    .wdata (req.key),
    .raddr ({pg[PGW-1:0], sc[SW-1:0]}),
    .rdata (kq)
  );

  assign eq = (kq == req.key);
  assign lt = ($signed(kq) < req.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      pg_bytes  <= PG_BYTES_RST;
      open      <= '0;
      out_valid <= 1'b0;
      kv        <= 1'b0;
    end else begin
      if (cfg_valid) pg_bytes <= cfg_data;
      if (cmd.open_new) open <= open + PW'(1);
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.scan_start) begin
        kv <= 1'b0;
      end else if (cmd.scan_step) begin
        kv <= (sc < fill);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= in_data;
      pg  <= '0;
    end else if (cmd.pg_inc) begin
      pg  <= pg + PW'(1);
    end
    if (cmd.cap) begin
      fo   <= pq_fo;
      rc   <= pq_rc;
      fill <= pq_fill;
    end else if (cmd.open_new) begin
      fo   <= '0;
      rc   <= '0;
      fill <= '0;
    end else if (cmd.upd) begin
      rc   <= rc_n;
    end
    if (cmd.scan_start || cmd.open_new) begin
      sc    <= '0;
      rank  <= '0;
      found <= 1'b0;
    end else if (cmd.scan_step) begin
      if (sc < fill) sc <= sc + SW1'(1);
      if (kv) begin
        if (eq) found <= 1'b1;
        if (lt) rank  <= rank + SW1'(1);
      end
    end
  end

  always_comb begin
    out_next = '0;
    out_next.total_pages = 6'(open);
    out_next.page_index  = 5'(pg);
    out_next.last        = 1'b1;
    case (req.opcode)
      OP_INSERT: begin
        if (sts.store_full && sts.pg_end) begin
          out_next.status     = ST_FULL;
          out_next.page_index = '0;
        end else begin
          out_next.status       = ST_INSERTED;
          out_next.page_records = rc;
        end
      end
      OP_SEARCH: begin
        if (sts.pg_end) begin
          out_next.status     = ST_NOT_FOUND;
          out_next.page_index = '0;
        end else begin
          out_next.status     = ST_FOUND;
          out_next.slot_index = 4'(rank);
        end
      end
      default: begin
        out_next.status       = ST_REPORT;
        out_next.page_records = sts.rpt_empty ? 16'd0 : rc;
        out_next.last         = sts.rpt_last;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= out_next;
    end
  end

  assign sts.op         = req.opcode;
  assign sts.pg_end     = (pg == open);
  assign sts.fits       = (pq_fill < SW1'(SLOTS_PER_PAGE)) && (need <= 20'(pg_bytes));
  assign sts.scan_done  = (sc == fill) && !kv;
  assign sts.found      = found;
  assign sts.store_full = (open >= PW'(MAX_PAGES));
  assign sts.rpt_empty  = (open == '0);
  assign sts.rpt_last   = (open == '0) || ((pg + PW'(1)) == open);
  assign sts.emit_ok    = !out_valid || !out_stall;

  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    open <= PW'(MAX_PAGES)) else $error("page count beyond bound");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> sc <= fill) else $error("slot scan past fill");
  a_upd_page: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> pg < open) else $error("update on unopened page");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> fill_n <= SW1'(SLOTS_PER_PAGE)) else $error("page slots overflow");
endmodule

// File: rtl/core/slotted_page_first_fit_store_top.sv
// Insert and search walk pages in order. An insert reads and checks each page
// (S_PG_RD, S_PG_CHK) until one passes the fit test; a search also scans the
// used slots of each page (S_SCAN) until the key is found; a report emits one
// result per page. One request is in work at a time; the output register lets
// the next request start while a result waits. Reset (rst, sync) empties the
// store and sets the page size to 4096; no memory clearing pass.
module slotted_page_first_fit_store_top #(
  parameter int MAX_PAGES      = sppf_pkg::MAX_PAGES_DEF,
  parameter int SLOTS_PER_PAGE = sppf_pkg::SLOTS_PER_PAGE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sppf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sppf_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data
);
  import sppf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sppf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sppf_dpath #(
    .MAX_PAGES      (MAX_PAGES),
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );
endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sppf_pkg::*;

  localparam int NPAGES = MAX_PAGES_DEF;
  localparam int NSLOTS = SLOTS_PER_PAGE_DEF;

  // page store mirror plus queue of expected responses
  class page_store_board;
    bit [15:0] pg_bytes;
    int unsigned open_pages;
    int unsigned free_off[NPAGES];
    int unsigned rec_cnt[NPAGES];
    bit [31:0] keys[NPAGES][NSLOTS];
    bit used[NPAGES][NSLOTS];
    out_t pending[$];
    int errors;

    function void clear();
      pg_bytes = PG_BYTES_RST;
      open_pages = 0;
      foreach (used[p, s]) used[p][s] = 0;
      foreach (rec_cnt[p]) begin
        rec_cnt[p] = 0;
        free_off[p] = 0;
      end
    endfunction

    function out_t mk(logic [2:0] st, int unsigned pg, int unsigned sl,
                      int unsigned recs, bit lst);
      out_t r;
      r.status = st;
      r.page_index = pg[4:0];
      r.slot_index = sl[3:0];
      r.page_records = recs[15:0];
      r.total_pages = open_pages[5:0];
      r.last = lst;
      return r;
    endfunction

    function int slot_of(int unsigned p, bit [31:0] k);
      for (int s = 0; s < NSLOTS; s++)
        if (used[p][s] && keys[p][s] == k) return s;
      return -1;
    endfunction

    function int unsigned nkeys(int unsigned p);
      int unsigned n;
      n = 0;
      for (int s = 0; s < NSLOTS; s++) n += used[p][s];
      return n;
    endfunction

    function void store_rec(int unsigned p, bit [31:0] k, int unsigned sz);
      if (slot_of(p, k) < 0) begin
        for (int s = 0; s < NSLOTS; s++)
          if (!used[p][s]) begin
            used[p][s] = 1;
            keys[p][s] = k;
            break;
          end
      end
      rec_cnt[p] = rec_cnt[p] + 1 > 65535 ? 65535 : rec_cnt[p] + 1;
      free_off[p] = free_off[p] + sz > 65535 ? 65535 : free_off[p] + sz;
    endfunction

    function void note_request(in_t req);
      int unsigned need;
      int unsigned rank;
      bit [31:0] k;
      k = req.key;
      case (req.opcode)
        OP_INSERT: begin
          for (int unsigned p = 0; p < open_pages; p++) begin
            need = free_off[p] + 16 + 4 * rec_cnt[p] + req.rec_bytes + 4;
            if (nkeys(p) < NSLOTS && need <= pg_bytes) begin
              store_rec(p, k, req.rec_bytes);
              pending.push_back(mk(ST_INSERTED, p, 0, rec_cnt[p], 1));
              return;
            end
          end
          if (open_pages >= NPAGES) begin
            pending.push_back(mk(ST_FULL, 0, 0, 0, 1));
            return;
          end
          open_pages++;
          free_off[open_pages-1] = 0;
          rec_cnt[open_pages-1] = 0;
          for (int s = 0; s < NSLOTS; s++) used[open_pages-1][s] = 0;
          store_rec(open_pages - 1, k, req.rec_bytes);
          pending.push_back(mk(ST_INSERTED, open_pages - 1, 0,
                               rec_cnt[open_pages-1], 1));
        end
        OP_SEARCH: begin
          for (int unsigned p = 0; p < open_pages; p++)
            if (slot_of(p, k) >= 0) begin
              rank = 0;
              for (int s = 0; s < NSLOTS; s++)
                if (used[p][s] && $signed(keys[p][s]) < $signed(k)) rank++;
              pending.push_back(mk(ST_FOUND, p, rank, 0, 1));
              return;
            end
          pending.push_back(mk(ST_NOT_FOUND, 0, 0, 0, 1));
        end
        OP_REPORT: begin
          if (open_pages == 0) pending.push_back(mk(ST_REPORT, 0, 0, 0, 1));
          for (int unsigned p = 0; p < open_pages; p++)
            pending.push_back(mk(ST_REPORT, p, 0, rec_cnt[p], p + 1 == open_pages));
        end
        default: ;
      endcase
    endfunction

    function void check_response(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  page_store_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit [31:0] key_pool[$];

  slotted_page_first_fit_store_top dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_response(out_data);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_request(logic [1:0] op, logic [15:0] sz, logic [31:0] k);
    in_t req;
    req.opcode = op;
    req.rec_bytes = sz;
    req.key = k;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(req);
    in_valid <= 0;
    // block is busy after an accept anyway
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_page_size(logic [15:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    board.pg_bytes = v;
  endtask

  task automatic random_request();
    int sel;
    logic [31:0] k;
    logic [15:0] sz;
    sel = $urandom_range(99);
    k = (key_pool.size() != 0 && $urandom_range(2) != 0)
        ? key_pool[$urandom_range(key_pool.size() - 1)] : $urandom;
    case ($urandom_range(3))
      0: sz = 16'($urandom);
      1: sz = 16'($urandom_range(8));
      default: sz = 16'($urandom_range(300));
    endcase
    if (sel < 60) begin
      send_request(OP_INSERT, sz, k);
      if (key_pool.size() < 40) key_pool.push_back(k);
    end else if (sel < 88) send_request(OP_SEARCH, sz, k);
    else if (sel < 97) send_request(OP_REPORT, sz, k);
    else send_request(2'd3, sz, k);
  endtask

  initial begin
    board.clear();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty report, misses, extremes, duplicates, unused opcode
    send_request(OP_REPORT, 0, 0);
    send_request(OP_SEARCH, 0, 32'h8000_0000);
    send_request(OP_INSERT, 16'hffff, 32'h7fff_ffff);
    send_request(OP_INSERT, 0, 32'h8000_0000);
    send_request(OP_INSERT, 0, 32'h8000_0000);
    send_request(OP_INSERT, 100, 32'hffff_ffff);
    send_request(OP_INSERT, 100, 0);
    send_request(OP_SEARCH, 0, 32'h7fff_ffff);
    send_request(OP_SEARCH, 0, 32'hffff_ffff);
    send_request(OP_SEARCH, 0, 0);
    send_request(2'd3, 16'hffff, 32'hffff_ffff);
    send_request(OP_REPORT, 0, 0);
    // fill page with distinct small keys, then repeat a held key
    for (int i = 1; i <= 17; i++) send_request(OP_INSERT, 1, 32'(i));
    send_request(OP_INSERT, 1, 5);
    send_request(OP_SEARCH, 1, 9);
    send_request(OP_REPORT, 0, 0);

    // saturation: zero page size opens a page per insert until full
    write_page_size(16'd0);
    for (int i = 0; i < 36; i++) send_request(OP_INSERT, 16'($urandom), $urandom);
    send_request(OP_REPORT, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_page_size(16'hffff);
        1: write_page_size(16'd200);
        2: write_page_size(16'd4096);
        3: write_page_size(16'd600);
        4: write_page_size(16'd1000);
        default: write_page_size(16'd40000);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int i = 0; i < 50; i++) begin
        random_request();
        if (i == 25) while (board.pending.size() != 0) @(posedge clk);
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("slotted_page_first_fit_store_top verification clean");
    else
      $display("slotted_page_first_fit_store_top verification failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("slotted_page_first_fit_store_top verification failed");
    $finish;
  end

endmodule
